// ===== rtl/core/mcu_pkg.sv =====
`timescale 1ns / 1ps

package mcu_pkg;

  localparam int COUNT_WIDTH = 8;
  localparam int SUM_WIDTH   = 16;

  localparam int PART_W    = 8;
  localparam int COEF_W    = 31;
  // count bits actually used from the part field
  localparam int CNT_W     = (COUNT_WIDTH < PART_W) ? COUNT_WIDTH : PART_W;
  localparam int TERM_W    = SUM_WIDTH + 1;
  localparam int MUL_B_W   = (TERM_W > COEF_W) ? TERM_W : COEF_W;
  localparam int PROD_W    = COEF_W + MUL_B_W;
  // acc * (sum + k) always fits here
  localparam int DVD_W     = COEF_W + TERM_W;
  localparam int DIV_BITS  = 4;
  localparam int DIV_STEPS = (DVD_W + DIV_BITS - 1) / DIV_BITS;
  localparam int DIV_W     = DIV_STEPS * DIV_BITS;
  localparam int STEP_CNT_W = (DIV_STEPS > 1) ? $clog2(DIV_STEPS) : 1;

  localparam logic [COEF_W-1:0] COEF_MAX = '1;

  typedef struct packed {
    logic [PART_W-1:0] part_count;
    logic              last_part;
  } in_word_t;

  typedef struct packed {
    logic [COEF_W-1:0] coefficient;
    logic              overflow;
  } out_word_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_CHK,
    S_MUL,
    S_DSTART,
    S_DWAIT,
    S_PMUL,
    S_PCHK,
    S_FIN
  } state_t;

endpackage

// ===== rtl/core/mcu_mul.sv =====
`timescale 1ns / 1ps

module mcu_mul (
  input  logic                         clk,
  input  logic [mcu_pkg::COEF_W-1:0]   a,
  input  logic [mcu_pkg::MUL_B_W-1:0]  b,
  output logic [mcu_pkg::PROD_W-1:0]   p
);
  import mcu_pkg::*;

  logic [PROD_W-1:0] p_r;

  always_ff @(posedge clk) begin
    p_r <= PROD_W'(a) * PROD_W'(b);
  end

  assign p = p_r;

endmodule

// ===== rtl/core/mcu_div.sv =====
`timescale 1ns / 1ps

module mcu_div (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  input  logic [mcu_pkg::DVD_W-1:0]   dividend,
  input  logic [mcu_pkg::CNT_W-1:0]   divisor,
  output logic                        done,
  output logic [mcu_pkg::DIV_W-1:0]   quotient
);
  import mcu_pkg::*;

  logic                  busy_r;
  logic                  done_r;
  logic [STEP_CNT_W-1:0] cnt_r;
  logic [CNT_W-1:0]      rem_r;
  logic [DIV_W-1:0]      quo_r;
  logic [CNT_W-1:0]      dsr_r;
  logic [CNT_W-1:0]      rem_nxt;
  logic [DIV_W-1:0]      quo_nxt;

  // restoring division, DIV_BITS quotient bits per cycle
  always_comb begin
    logic [CNT_W:0]   trial;
    logic [CNT_W-1:0] rem_c;
    logic [DIV_W-1:0] quo_c;
    rem_c = rem_r;
    quo_c = quo_r;
    trial = '0;
    for (int i = 0; i < DIV_BITS; i++) begin
      trial = {rem_c, quo_c[DIV_W-1]};
      quo_c = {quo_c[DIV_W-2:0], 1'b0};
      if (trial >= {1'b0, dsr_r}) begin
        trial    = trial - {1'b0, dsr_r};
        quo_c[0] = 1'b1;
      end
      rem_c = trial[CNT_W-1:0];
    end
    rem_nxt = rem_c;
    quo_nxt = quo_c;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == STEP_CNT_W'(DIV_STEPS - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= '0;
      quo_r <= DIV_W'(dividend);
      dsr_r <= divisor;
    end else if (busy_r) begin
      rem_r <= rem_nxt;
      quo_r <= quo_nxt;
    end
  end

  assign done     = done_r;
  assign quotient = quo_r;

endmodule

// ===== rtl/core/multinomial_coefficient_unit.sv =====
`timescale 1ns / 1ps

// Multinomial coefficient unit.
// Input channel (in_valid/in_ready/in_data) takes one part count per word;
// last_part closes the sequence. Only the closing word yields an output word
// (out_valid/out_ready/out_data): the coefficient (sum of parts)! / prod(b!),
// or the saturated maximum with overflow set.
// Each part count b builds C(sum+b, b) one factor at a time on one shared
// multiplier and one shared 4-bit-per-cycle divider: per unit of b a check,
// a multiply, a divider start, the divide and a quotient update; around these
// come the accept, the product multiply and the sum update. A zero count skips
// the factor loop; a sequence already in overflow skips to the sum update.
// in_ready is high only while the sequencer is idle.
// The result sits in an output register; the next sequence may start while it
// waits. If a new closing part finishes while the previous result is still not
// taken, the sequencer holds until out_ready frees the register.
// Reset (rst_n low, synchronous) clears the running sum, sets the running
// product to 1, clears the overflow flag and drops out_valid.

module multinomial_coefficient_unit (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  mcu_pkg::in_word_t  in_data,
  output logic               out_valid,
  input  logic               out_ready,
  output mcu_pkg::out_word_t out_data
);
  import mcu_pkg::*;

  state_t            state_r;
  state_t            state_nxt;
  logic [SUM_WIDTH-1:0] sum_r;
  logic [COEF_W-1:0] prod_r;
  logic              ovf_r;
  logic [COEF_W-1:0] acc_r;
  logic [CNT_W:0]    k_r;
  logic [CNT_W-1:0]  b_r;
  logic              last_r;
  logic              out_valid_r;
  out_word_t         out_data_r;

  logic [COEF_W-1:0]  mul_a;
  logic [MUL_B_W-1:0] mul_b;
  logic [PROD_W-1:0]  mul_p;
  logic               div_start;
  logic               div_done;
  logic [DIV_W-1:0]   div_quo;
  logic               quo_hi;
  logic               prod_hi;
  logic               sel_prod;
  logic               fin_go;
  logic [TERM_W-1:0]  term;
  logic [SUM_WIDTH:0] sum_add;
  logic [SUM_WIDTH-1:0] sum_sat;
  logic               sum_carry;

  assign term      = TERM_W'(sum_r) + TERM_W'(k_r);
  assign sum_add   = (SUM_WIDTH + 1)'(sum_r) + (SUM_WIDTH + 1)'(b_r);
  assign sum_carry = sum_add[SUM_WIDTH];
  assign sum_sat   = sum_carry ? '1 : sum_add[SUM_WIDTH-1:0];
  assign quo_hi    = |div_quo[DIV_W-1:COEF_W];
  assign prod_hi   = |mul_p[PROD_W-1:COEF_W];

  assign mul_a = sel_prod ? prod_r : acc_r;
  assign mul_b = sel_prod ? MUL_B_W'(acc_r) : MUL_B_W'(term);

  mcu_mul u_mul (
    .clk (clk),
    .a   (mul_a),
    .b   (mul_b),
    .p   (mul_p)
  );

  mcu_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (mul_p[DVD_W-1:0]),
    .divisor  (k_r[CNT_W-1:0]),
    .done     (div_done),
    .quotient (div_quo)
  );

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE:   if (in_valid) state_nxt = S_CHK;
      S_CHK: begin
        if (ovf_r) state_nxt = S_FIN;
        else if (k_r > {1'b0, b_r}) state_nxt = S_PMUL;
        else state_nxt = S_MUL;
      end
      S_MUL:    state_nxt = S_DSTART;
      S_DSTART: state_nxt = S_DWAIT;
      S_DWAIT: begin
        if (div_done) state_nxt = quo_hi ? S_FIN : S_CHK;
      end
      S_PMUL:   state_nxt = S_PCHK;
      S_PCHK:   state_nxt = S_FIN;
      S_FIN:    if (fin_go) state_nxt = S_IDLE;
      default:  state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    in_ready  = 1'b0;
    div_start = 1'b0;
    sel_prod  = 1'b0;
    fin_go    = 1'b0;
    case (state_r)
      S_IDLE:   in_ready = 1'b1;
      S_DSTART: div_start = 1'b1;
      S_PMUL:   sel_prod = 1'b1;
      S_FIN:    fin_go = !(last_r && out_valid_r && !out_ready);
      default: begin
        in_ready = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      sum_r       <= '0;
      prod_r      <= COEF_W'(1);
      ovf_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (out_valid_r && out_ready && !(fin_go && last_r)) out_valid_r <= 1'b0;
      case (state_r)
        S_DWAIT: begin
          if (div_done && quo_hi) ovf_r <= 1'b1;
        end
        S_PCHK: begin
          if (prod_hi) ovf_r <= 1'b1;
          else prod_r <= mul_p[COEF_W-1:0];
        end
        S_FIN: begin
          if (fin_go) begin
            if (last_r) begin
              out_valid_r <= 1'b1;
              sum_r       <= '0;
              prod_r      <= COEF_W'(1);
              ovf_r       <= 1'b0;
            end else begin
              sum_r <= sum_sat;
              ovf_r <= ovf_r | sum_carry;
            end
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          b_r    <= in_data.part_count[CNT_W-1:0];
          last_r <= in_data.last_part;
          acc_r  <= COEF_W'(1);
          k_r    <= (CNT_W + 1)'(1);
        end
      end
      S_DWAIT: begin
        // exact division: quotient is the next partial binomial
        if (div_done && !quo_hi) begin
          acc_r <= div_quo[COEF_W-1:0];
          k_r   <= k_r + 1'b1;
        end
      end
      S_FIN: begin
        if (fin_go && last_r) begin
          out_data_r.overflow    <= ovf_r | sum_carry;
          out_data_r.coefficient <= (ovf_r | sum_carry) ? COEF_MAX : prod_r;
        end
      end
      default: begin
      end
    endcase
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  a_ovf_sat: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_data.overflow) |-> (out_data.coefficient == COEF_MAX))
    else $error("overflow word without saturated coefficient");

  a_div_sync: assert property (@(posedge clk) disable iff (!rst_n)
    div_done |-> (state_r == S_DWAIT))
    else $error("divider finished outside its wait state");

  a_fin_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_FIN && last_r && out_valid_r && !out_ready) |=> (state_r == S_FIN))
    else $error("closing part left while output register still full");

  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> !in_ready)
    else $error("second word accepted while sequence step in progress");

endmodule

// ===== tb/testbench.sv =====
`timescale 1ns / 1ps

module testbench;
  import mcu_pkg::*;

  localparam longint unsigned COEF_LIMIT = (64'd1 << COEF_W) - 1;
  localparam longint unsigned SUM_LIMIT  = (64'd1 << SUM_WIDTH) - 1;
  localparam int unsigned RANDOM_WORDS   = 1126;
  localparam int unsigned SUM_RUN_AT     = 300;
  localparam int unsigned STEADY_FROM    = 400;
  localparam int unsigned STEADY_TO      = 600;

  typedef struct {
    logic [PART_W-1:0] cnt;
    bit                last;
    bit                lit;
    logic [COEF_W-1:0] coef;
    bit                ovf;
  } part_row_t;

  typedef struct {
    in_word_t  word;
    bit        hold;  // sender waits for all results first
    bit        lit;
    out_word_t lit_res;
  } stim_t;

  // directed parts; literal results only where obvious
  part_row_t directed_rows [24] = '{
    '{8'd0,   1'b1, 1'b1, 31'd1, 1'b0},
    '{8'd255, 1'b1, 1'b1, 31'd1, 1'b0},
    '{8'd1,   1'b1, 1'b1, 31'd1, 1'b0},
    '{8'd0,   1'b0, 1'b0, 31'd0, 1'b0},
    '{8'd0,   1'b1, 1'b1, 31'd1, 1'b0},
    '{8'd1,   1'b0, 1'b0, 31'd0, 1'b0},
    '{8'd1,   1'b1, 1'b0, 31'd0, 1'b0},
    '{8'd3,   1'b0, 1'b0, 31'd0, 1'b0},
    '{8'd2,   1'b0, 1'b0, 31'd0, 1'b0},
    '{8'd1,   1'b1, 1'b0, 31'd0, 1'b0},
    '{8'd255, 1'b0, 1'b0, 31'd0, 1'b0},
    '{8'd1,   1'b1, 1'b0, 31'd0, 1'b0},
    '{8'd0,   1'b0, 1'b0, 31'd0, 1'b0},
    '{8'd5,   1'b0, 1'b0, 31'd0, 1'b0},
    '{8'd0,   1'b1, 1'b1, 31'd1, 1'b0},
    '{8'd20,  1'b0, 1'b0, 31'd0, 1'b0},
    '{8'd20,  1'b1, 1'b1, COEF_MAX, 1'b1},
    '{8'd255, 1'b0, 1'b0, 31'd0, 1'b0},
    '{8'd255, 1'b1, 1'b1, COEF_MAX, 1'b1},
    '{8'd16,  1'b0, 1'b0, 31'd0, 1'b0},
    '{8'd16,  1'b1, 1'b0, 31'd0, 1'b0},
    '{8'd12,  1'b0, 1'b0, 31'd0, 1'b0},
    '{8'd12,  1'b0, 1'b0, 31'd0, 1'b0},
    '{8'd12,  1'b1, 1'b0, 31'd0, 1'b0}
  };

  logic      clk;
  logic      rst_n = 1'b0;
  logic      in_valid = 1'b0;
  logic      in_ready;
  in_word_t  in_data = '0;
  logic      out_valid;
  logic      out_ready = 1'b0;
  out_word_t out_data;

  stim_t     stim_q[$];
  out_word_t coef_due_q[$];

  longint unsigned run_sum = 0;
  longint unsigned run_product = 1;
  bit              run_overflow = 1'b0;

  int unsigned     mismatches = 0;
  int unsigned     words_sent = 0;
  bit              steady = 1'b0;
  longint unsigned cycle_count = 0;
  longint unsigned cycle_limit = 64'hFFFF_FFFF;

  multinomial_coefficient_unit dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // C(base+cnt, cnt) built factor by factor; COEF_LIMIT+1 once it gets too big
  function automatic longint unsigned binom_capped(longint unsigned base,
                                                   longint unsigned cnt);
    longint unsigned acc = 1;
    for (longint unsigned k = 1; k <= cnt; k++) begin
      acc = (acc * (base + k)) / k;
      if (acc > COEF_LIMIT) return COEF_LIMIT + 1;
    end
    return acc;
  endfunction

  task automatic fold_part(input in_word_t w, output bit emits, output out_word_t res);
    longint unsigned b;
    longint unsigned c;
    longint unsigned p;
    b = 64'(w.part_count[CNT_W-1:0]);
    emits = 1'b0;
    res = '0;
    if (!run_overflow) begin
      c = binom_capped(run_sum, b);
      if (c > COEF_LIMIT) begin
        run_overflow = 1'b1;
      end else begin
        p = run_product * c;
        if (p > COEF_LIMIT) run_overflow = 1'b1;
        else run_product = p;
      end
    end
    if (run_sum + b > SUM_LIMIT) begin
      run_sum = SUM_LIMIT;
      run_overflow = 1'b1;
    end else begin
      run_sum = run_sum + b;
    end
    if (w.last_part) begin
      emits = 1'b1;
      res.coefficient = run_overflow ? COEF_MAX : run_product[COEF_W-1:0];
      res.overflow = run_overflow;
      run_sum = 0;
      run_product = 1;
      run_overflow = 1'b0;
    end
  endtask

  task automatic push_part(input logic [PART_W-1:0] cnt, input bit last, input bit hold);
    stim_t s;
    s.word.part_count = cnt;
    s.word.last_part = last;
    s.hold = hold;
    s.lit = 1'b0;
    s.lit_res = '0;
    stim_q.push_back(s);
  endtask

  function automatic logic [PART_W-1:0] pick_count();
    int unsigned r = $urandom_range(99);
    if (r < 75) return PART_W'($urandom_range(6));
    if (r < 93) return PART_W'($urandom_range(40, 7));
    return PART_W'($urandom_range(255, 41));
  endfunction

  task automatic build_stimulus();
    stim_t s;
    int unsigned added = 0;
    int unsigned len;
    bit          sum_run_done = 1'b0;
    bit          first = 1'b1;
    foreach (directed_rows[i]) begin
      s.word.part_count = directed_rows[i].cnt;
      s.word.last_part = directed_rows[i].last;
      s.hold = 1'b0;
      s.lit = directed_rows[i].lit;
      s.lit_res.coefficient = directed_rows[i].coef;
      s.lit_res.overflow = directed_rows[i].ovf;
      stim_q.push_back(s);
    end
    while (added < RANDOM_WORDS) begin
      if (!sum_run_done && added >= SUM_RUN_AT) begin
        // product overflows early, then the sum runs past its range
        push_part(8'd20, 1'b0, 1'b1);
        push_part(8'd20, 1'b0, 1'b0);
        for (int n = 0; n < 257; n++) push_part(8'd255, n == 256, 1'b0);
        added += 259;
        sum_run_done = 1'b1;
      end else if ($urandom_range(9) == 0) begin
        // long runs of tiny parts probe the edge of the product range
        len = $urandom_range(14, 8);
        for (int n = 0; n < len; n++)
          push_part(PART_W'($urandom_range(2)), n == len - 1, first && n == 0);
        added += len;
      end else begin
        len = $urandom_range(5, 1);
        for (int n = 0; n < len; n++)
          push_part(pick_count(), n == len - 1, first && n == 0);
        added += len;
      end
      first = 1'b0;
    end
  endtask

  task automatic flag_mismatch(input string note);
    mismatches++;
    if (mismatches <= 10) $display("mismatch: %s", note);
  endtask

  // receiver
  always @(posedge clk) begin
    out_ready <= steady || ($urandom_range(99) >= 15);
  end

  // result checker
  always @(posedge clk) begin
    out_word_t due;
    if (rst_n && out_valid && out_ready) begin
      if (coef_due_q.size() == 0) begin
        flag_mismatch($sformatf("unexpected word coefficient=%0d overflow=%0b",
                                out_data.coefficient, out_data.overflow));
      end else begin
        due = coef_due_q.pop_front();
        if (out_data.coefficient !== due.coefficient)
          flag_mismatch($sformatf("coefficient expected %0d got %0d",
                                  due.coefficient, out_data.coefficient));
        if (out_data.overflow !== due.overflow)
          flag_mismatch($sformatf("overflow expected %0b got %0b",
                                  due.overflow, out_data.overflow));
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > cycle_limit) begin
      $display("tb: failure");
      $finish;
    end
  end

  initial begin
    stim_t           s;
    out_word_t       res;
    bit              emits;
    longint unsigned budget;
    build_stimulus();
    budget = 0;
    // budget per word grows with its part count; leave room for stalls
    foreach (stim_q[i]) budget += 30 + 16 * stim_q[i].word.part_count + 80;
    cycle_limit = 4 * budget + 20000;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    foreach (stim_q[i]) begin
      s = stim_q[i];
      if (s.hold && coef_due_q.size() != 0) begin
        in_valid <= 1'b0;
        while (coef_due_q.size() != 0) @(posedge clk);
      end
      while (!steady && $urandom_range(99) < 15) begin
        in_valid <= 1'b0;
        @(posedge clk);
      end
      in_valid <= 1'b1;
      in_data <= s.word;
      do @(posedge clk); while (!in_ready);
      fold_part(s.word, emits, res);
      if (emits) coef_due_q.push_back(s.lit ? s.lit_res : res);
      words_sent++;
      steady = (words_sent >= STEADY_FROM) && (words_sent < STEADY_TO);
    end
    in_valid <= 1'b0;
    steady = 1'b0;
    while (coef_due_q.size() != 0) @(posedge clk);
    repeat (100) @(posedge clk);
    if (mismatches == 0 && coef_due_q.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
